[rtl/icgc_pkg.sv]
// Shared types, constants and gradient stop tables for the iteration count color map.
package icgc_pkg;

    localparam int NUM_SETS  = 9;
    localparam int MAX_SEGS  = 5;
    localparam int CH_WIDTH  = 24;

    localparam logic [1:0] REG_MAX_ITER   = 2'd0;
    localparam logic [1:0] REG_COLOR_SET  = 2'd1;
    localparam logic [1:0] REG_DESCENDING = 2'd2;
    localparam logic [1:0] REG_BACKGROUND = 2'd3;

    // Channel levels: value * 255 * 65536
    localparam logic [23:0] FULL  = 24'd16711680;
    localparam logic [23:0] HALF  = 24'd8355840;
    localparam logic [23:0] RED_R = 24'd16059924;
    localparam logic [23:0] RED_G = 24'd1771438;
    localparam logic [23:0] RED_B = 24'd2155807;
    localparam logic [23:0] VIO_R = 24'd7336428;
    localparam logic [23:0] VIO_G = 24'd267387;
    localparam logic [23:0] VIO_B = 24'd12316508;
    localparam logic [23:0] GRN_R = 24'd10478223;
    localparam logic [23:0] GRN_G = 24'd15993078;
    localparam logic [23:0] GRN_B = 24'd6818365;

    typedef struct packed {
        logic [4:0]  pos;
        logic [23:0] r;
        logic [23:0] g;
        logic [23:0] b;
    } stop_t;

    typedef struct packed {
        logic bg;
        logic fb;
        logic odd;
    } flags_t;

    function automatic stop_t mk_stop(input logic [4:0] pos, input logic [23:0] r,
                                      input logic [23:0] g, input logic [23:0] b);
        stop_t s;
        s.pos = pos;
        s.r   = r;
        s.g   = g;
        s.b   = b;
        return s;
    endfunction

    function automatic logic [2:0] stop_cnt(input logic [3:0] set);
        logic [2:0] n;
        case (set)
            4'd0, 4'd3, 4'd8: n = 3'd2;
            4'd4:             n = 3'd3;
            4'd2:             n = 3'd4;
            4'd1, 4'd5, 4'd7: n = 3'd5;
            4'd6:             n = 3'd6;
            default:          n = 3'd0;
        endcase
        return n;
    endfunction

    function automatic stop_t stop_at(input logic [3:0] set, input logic [2:0] idx);
        stop_t s;
        s = mk_stop(5'd0, 24'd0, 24'd0, 24'd0);
        case (set)
            4'd0:
                case (idx)
                    3'd1:    s = mk_stop(5'd20, FULL, 24'd0, 24'd0);
                    default: ;
                endcase
            4'd1:
                case (idx)
                    3'd1:    s = mk_stop(5'd5, 24'd0, FULL, HALF);
                    3'd2:    s = mk_stop(5'd10, 24'd0, FULL, FULL);
                    3'd3:    s = mk_stop(5'd15, 24'd0, HALF, FULL);
                    3'd4:    s = mk_stop(5'd20, 24'd0, FULL, FULL);
                    default: ;
                endcase
            4'd2:
                case (idx)
                    3'd1:    s = mk_stop(5'd5, FULL, 24'd0, 24'd0);
                    3'd2:    s = mk_stop(5'd10, FULL, FULL, 24'd0);
                    3'd3:    s = mk_stop(5'd20, FULL, 24'd0, 24'd0);
                    default: ;
                endcase
            4'd3:
                case (idx)
                    3'd1:    s = mk_stop(5'd20, 24'd0, 24'd0, FULL);
                    default: ;
                endcase
            4'd4:
                case (idx)
                    3'd1:    s = mk_stop(5'd10, FULL, 24'd0, 24'd0);
                    3'd2:    s = mk_stop(5'd20, 24'd0, 24'd0, FULL);
                    default: ;
                endcase
            4'd5:
                case (idx)
                    3'd1:    s = mk_stop(5'd5, RED_R, RED_G, RED_B);
                    3'd2:    s = mk_stop(5'd10, VIO_R, VIO_G, VIO_B);
                    3'd3:    s = mk_stop(5'd15, GRN_R, GRN_G, GRN_B);
                    3'd4:    s = mk_stop(5'd20, VIO_R, VIO_G, VIO_B);
                    default: ;
                endcase
            4'd6:
                case (idx)
                    3'd1:    s = mk_stop(5'd4, RED_R, RED_G, RED_B);
                    3'd2:    s = mk_stop(5'd8, VIO_R, VIO_G, VIO_B);
                    3'd3:    s = mk_stop(5'd10, GRN_R, GRN_G, GRN_B);
                    3'd4:    s = mk_stop(5'd12, VIO_R, VIO_G, VIO_B);
                    3'd5:    s = mk_stop(5'd20, RED_R, RED_G, RED_B);
                    default: ;
                endcase
            4'd7:
                case (idx)
                    3'd1:    s = mk_stop(5'd5, HALF, FULL, 24'd0);
                    3'd2:    s = mk_stop(5'd10, FULL, FULL, 24'd0);
                    3'd3:    s = mk_stop(5'd15, FULL, HALF, 24'd0);
                    3'd4:    s = mk_stop(5'd20, FULL, FULL, 24'd0);
                    default: ;
                endcase
            4'd8:
                case (idx)
                    3'd1:    s = mk_stop(5'd20, FULL, FULL, FULL);
                    default: ;
                endcase
            default: ;
        endcase
        return s;
    endfunction

endpackage

[rtl/icgc_if.sv]
// Stream interfaces for iteration counts in and pixel colors out.
interface icgc_count_if #(parameter int WIDTH = 16);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] iteration_count;

    modport source (output valid, output iteration_count, input ready);
    modport sink   (input valid, input iteration_count, output ready);
endinterface

interface icgc_color_if;
    logic        valid;
    logic        ready;
    logic [30:0] pixel_color;

    modport source (output valid, output pixel_color, input ready);
    modport sink   (input valid, input pixel_color, output ready);
endinterface

[rtl/iteration_count_gradient_color.sv]
// Pipelined iteration count to gradient color map.
//
//  channel   dir  payload                      handshake
//  counts    in   iteration_count[W-1:0]       valid/ready
//  colors    out  pixel_color[30:0]            valid/ready
//  cfg       in   cfg_index, cfg_data          cfg_wen, no wait
//
// One item per clock unless the output stalls or the sequencer is busy; the stages are
// range check, segment select, multiply, sum, eight quotient-bit stages of the
// per-channel divider and the output register. After reset and after every register
// write a sequencer computes max_iterations / 5 and then each segment length in turn;
// ready stays low until it is done.
// The whole pipeline holds while the output register is full and not taken.
module iteration_count_gradient_color
    import icgc_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
)
(
    input  logic clk,
    input  logic rst_n,
    icgc_count_if.sink   counts,
    icgc_color_if.source colors,
    input  logic                                              cfg_wen,
    input  logic [1:0]                                        cfg_index,
    input  logic [((COUNT_WIDTH > 31) ? COUNT_WIDTH : 31)-1:0] cfg_data
);

    localparam int W  = COUNT_WIDTH;
    localparam int PW = CH_WIDTH + W;
    localparam int NW = W + 26;
    localparam int QW = 2 * W;
    localparam int DW = W + 3;
    localparam int QS = W + 2;

    // ceil(2^QS / 5): floor(m * RECIP5 / 2^QS) is m / 5 for every W-bit m
    localparam logic [W-1:0] RECIP5 = W'(((64'd1 << QS) + 64'd4) / 64'd5);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_QUOT = 2'd1;
    localparam logic [1:0] ST_SEGS = 2'd2;

    // Configuration
    logic [W-1:0] max_iter_reg;
    logic [3:0]   set_reg;
    logic         desc_reg;
    logic [30:0]  bg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_iter_reg <= W'(256);
            set_reg      <= 4'd0;
            desc_reg     <= 1'b0;
            bg_reg       <= 31'd0;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                REG_MAX_ITER:   max_iter_reg <= cfg_data[W-1:0];
                REG_COLOR_SET:  set_reg      <= cfg_data[3:0];
                REG_DESCENDING: desc_reg     <= cfg_data[0];
                REG_BACKGROUND: bg_reg       <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // Segment length sequencer: n = (dp*m + 10) / 20
    // With m = 5*q5 + r5 and d = dp*q5: n = d/4 + (5*(d mod 4) + dp*r5 + 10) / 20
    logic [1:0]       state_reg;
    logic [2:0]       seg_reg;
    logic [W-1:0]     q5_reg;
    logic [2:0]       r5_reg;
    logic [W:0]       acc_reg;
    logic [W-1:0]     n_reg   [MAX_SEGS];
    logic [W:0]       end_reg [MAX_SEGS];

    logic [QW-1:0] sq_prod;
    logic [W-1:0]  sq_q5;
    logic [2:0]    sq_r5;
    stop_t         sq_lo;
    stop_t         sq_hi;
    logic [4:0]    sq_dp;
    logic [DW-1:0] sq_d;
    logic [6:0]    sq_t;
    logic [2:0]    sq_t20;
    logic [W-1:0]  sq_n;
    logic [W:0]    sq_end;
    logic          sq_seg_valid;

    always_comb
    begin
        sq_prod      = QW'(max_iter_reg) * QW'(RECIP5);
        sq_q5        = W'(sq_prod[QW-1:QS]);
        sq_r5        = 3'(max_iter_reg - ((sq_q5 << 2) + sq_q5));
        sq_lo        = stop_at(set_reg, seg_reg);
        sq_hi        = stop_at(set_reg, seg_reg + 3'd1);
        sq_dp        = sq_hi.pos - sq_lo.pos;
        sq_d         = DW'(sq_dp) * DW'(q5_reg);
        sq_t         = 7'(sq_d[1:0]) * 7'd5 + 7'(sq_dp) * 7'(r5_reg) + 7'd10;
        if (sq_t >= 7'd100)
            sq_t20 = 3'd5;
        else if (sq_t >= 7'd80)
            sq_t20 = 3'd4;
        else if (sq_t >= 7'd60)
            sq_t20 = 3'd3;
        else if (sq_t >= 7'd40)
            sq_t20 = 3'd2;
        else if (sq_t >= 7'd20)
            sq_t20 = 3'd1;
        else
            sq_t20 = 3'd0;
        sq_n         = W'(sq_d >> 2) + W'(sq_t20);
        sq_end       = acc_reg + {1'b0, sq_n};
        sq_seg_valid = ((seg_reg + 3'd1) < stop_cnt(set_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_QUOT;
            seg_reg   <= 3'd0;
            q5_reg    <= '0;
            r5_reg    <= 3'd0;
            acc_reg   <= '0;
        end
        else if (cfg_wen)
        begin
            // Restart from the first segment with the new settings
            state_reg <= ST_QUOT;
            seg_reg   <= 3'd0;
            acc_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                ST_QUOT:
                begin
                    q5_reg    <= sq_q5;
                    r5_reg    <= sq_r5;
                    state_reg <= ST_SEGS;
                end
                ST_SEGS:
                begin
                    acc_reg <= sq_end;
                    if (seg_reg == 3'(MAX_SEGS - 1))
                        state_reg <= ST_IDLE;
                    else
                        seg_reg <= seg_reg + 3'd1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_SEGS && !cfg_wen)
        begin
            n_reg[seg_reg]   <= sq_n;
            // Unused segments never match
            end_reg[seg_reg] <= sq_seg_valid ? sq_end : '0;
        end
    end

    // Item pipeline
    logic adv;
    logic in_accept;
    logic out_valid_reg;

    assign adv          = !out_valid_reg || colors.ready;
    assign counts.ready = (state_reg == ST_IDLE) && adv;
    assign in_accept    = counts.valid && counts.ready;

    // Stage 1: range check and mirroring
    logic         st1_v_reg;
    flags_t       st1_f_reg;
    logic [W-1:0] st1_idx_reg;
    logic [W-1:0] in_cnt;

    assign in_cnt = counts.iteration_count;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st1_v_reg <= 1'b0;
        else if (adv)
            st1_v_reg <= in_accept;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            st1_f_reg.bg  <= (in_cnt >= max_iter_reg);
            st1_f_reg.fb  <= (set_reg >= 4'(NUM_SETS));
            st1_f_reg.odd <= in_cnt[0];
            st1_idx_reg   <= desc_reg ? (max_iter_reg - W'(1) - in_cnt) : in_cnt;
        end
    end

    // Stage 2: segment select and stop lookup
    logic                st2_v_reg;
    flags_t              st2_f_reg;
    logic [W-1:0]        st2_k_reg;
    logic [W-1:0]        st2_n_reg;
    logic [W-1:0]        st2_nk_reg;
    logic [CH_WIDTH-1:0] st2_c0_reg [3];
    logic [CH_WIDTH-1:0] st2_c1_reg [3];

    logic         s2_found;
    logic [2:0]   s2_seg;
    logic [2:0]   s2_lo_i;
    logic [2:0]   s2_hi_i;
    logic [W-1:0] s2_k;
    logic [W-1:0] s2_n;
    stop_t        s2_lo;
    stop_t        s2_hi;

    always_comb
    begin
        s2_found = 1'b0;
        s2_seg   = 3'd0;
        for (int j = MAX_SEGS - 1; j >= 0; j--)
        begin
            if (end_reg[j] > {1'b0, st1_idx_reg})
            begin
                s2_found = 1'b1;
                s2_seg   = 3'(j);
            end
        end
        if (s2_found)
        begin
            s2_lo_i = s2_seg;
            s2_hi_i = s2_seg + 3'd1;
            s2_n    = n_reg[s2_seg];
            s2_k    = st1_idx_reg - (end_reg[s2_seg][W-1:0] - n_reg[s2_seg]);
        end
        else
        begin
            // Past the last rounded segment: last stop color
            s2_lo_i = stop_cnt(set_reg) - 3'd1;
            s2_hi_i = s2_lo_i;
            s2_n    = W'(1);
            s2_k    = '0;
        end
        s2_lo = stop_at(set_reg, s2_lo_i);
        s2_hi = stop_at(set_reg, s2_hi_i);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st2_v_reg <= 1'b0;
        else if (adv)
            st2_v_reg <= st1_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            st2_f_reg     <= st1_f_reg;
            st2_k_reg     <= s2_k;
            st2_n_reg     <= s2_n;
            st2_nk_reg    <= s2_n - s2_k;
            st2_c0_reg[0] <= s2_lo.r;
            st2_c0_reg[1] <= s2_lo.g;
            st2_c0_reg[2] <= s2_lo.b;
            st2_c1_reg[0] <= s2_hi.r;
            st2_c1_reg[1] <= s2_hi.g;
            st2_c1_reg[2] <= s2_hi.b;
        end
    end

    // Stage 3: weight products
    logic          st3_v_reg;
    flags_t        st3_f_reg;
    logic [W-1:0]  st3_n_reg;
    logic [PW-1:0] st3_a_reg [3];
    logic [PW-1:0] st3_b_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st3_v_reg <= 1'b0;
        else if (adv)
            st3_v_reg <= st2_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            st3_f_reg <= st2_f_reg;
            st3_n_reg <= st2_n_reg;
            for (int c = 0; c < 3; c++)
            begin
                st3_a_reg[c] <= PW'(st2_c0_reg[c]) * PW'(st2_nk_reg);
                st3_b_reg[c] <= PW'(st2_c1_reg[c]) * PW'(st2_k_reg);
            end
        end
    end

    // Stage 4: rounding dividend and divisor
    logic          st4_v_reg;
    flags_t        st4_f_reg;
    logic [NW-1:0] st4_num_reg [3];
    logic [NW-1:0] st4_den_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st4_v_reg <= 1'b0;
        else if (adv)
            st4_v_reg <= st3_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            st4_f_reg   <= st3_f_reg;
            st4_den_reg <= NW'(st3_n_reg) << 17;
            for (int c = 0; c < 3; c++)
            begin
                st4_num_reg[c] <= ((NW'(st3_a_reg[c]) + NW'(st3_b_reg[c])) << 1)
                                  + (NW'(st3_n_reg) << 16);
            end
        end
    end

    // Divider: one quotient bit per stage, MSB first
    logic          dv_v_reg   [8];
    flags_t        dv_f_reg   [8];
    logic [NW-1:0] dv_den_reg [8];
    logic [NW-1:0] dv_rem_reg [8][3];
    logic [7:0]    dv_q_reg   [8][3];

    for (genvar i = 0; i < 8; i++)
    begin : g_div
        logic          v_in;
        flags_t        f_in;
        logic [NW-1:0] den_in;
        logic [NW-1:0] rem_in [3];
        logic [7:0]    q_in   [3];
        logic [NW-1:0] den_sh;

        if (i == 0)
        begin : g_first
            always_comb
            begin
                v_in   = st4_v_reg;
                f_in   = st4_f_reg;
                den_in = st4_den_reg;
                for (int c = 0; c < 3; c++)
                begin
                    rem_in[c] = st4_num_reg[c];
                    q_in[c]   = 8'd0;
                end
            end
        end
        else
        begin : g_next
            always_comb
            begin
                v_in   = dv_v_reg[i-1];
                f_in   = dv_f_reg[i-1];
                den_in = dv_den_reg[i-1];
                for (int c = 0; c < 3; c++)
                begin
                    rem_in[c] = dv_rem_reg[i-1][c];
                    q_in[c]   = dv_q_reg[i-1][c];
                end
            end
        end

        assign den_sh = den_in << (7 - i);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_v_reg[i] <= 1'b0;
            else if (adv)
                dv_v_reg[i] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_f_reg[i]   <= f_in;
                dv_den_reg[i] <= den_in;
                for (int c = 0; c < 3; c++)
                begin
                    if (rem_in[c] >= den_sh)
                    begin
                        dv_rem_reg[i][c] <= rem_in[c] - den_sh;
                        dv_q_reg[i][c]   <= q_in[c] | (8'd1 << (7 - i));
                    end
                    else
                    begin
                        dv_rem_reg[i][c] <= rem_in[c];
                        dv_q_reg[i][c]   <= q_in[c];
                    end
                end
            end
        end
    end

    // Output register
    logic [30:0] pixel_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= dv_v_reg[7];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (dv_f_reg[7].bg)
                pixel_reg <= bg_reg;
            else if (dv_f_reg[7].fb)
                pixel_reg <= dv_f_reg[7].odd ? 31'h0FFFFFF : 31'd0;
            else
                pixel_reg <= {7'd0, dv_q_reg[7][0], dv_q_reg[7][1], dv_q_reg[7][2]};
        end
    end

    assign colors.valid       = out_valid_reg;
    assign colors.pixel_color = pixel_reg;

    // Checks
    a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wen |=> !counts.ready)
        else $error("input taken while segment table is being rebuilt");

    a_ready_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        counts.ready |-> (state_reg == ST_IDLE))
        else $error("ready raised during segment calculation");

    a_div_remainder: assert property (@(posedge clk) disable iff (!rst_n)
        dv_v_reg[7] |-> (dv_rem_reg[7][0] < dv_den_reg[7]
                         && dv_rem_reg[7][1] < dv_den_reg[7]
                         && dv_rem_reg[7][2] < dv_den_reg[7]))
        else $error("divider remainder not below divisor");

endmodule

[test/icgc_checker.sv]
// Checker for the iteration count color map: predicts colors and compares them.
module icgc_checker
    import icgc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        count_fire,
    input  logic [15:0] count_in,
    input  logic        color_fire,
    input  logic [30:0] color_out,
    input  logic        cfg_wen,
    input  logic [1:0]  cfg_index,
    input  logic [30:0] cfg_data,
    output int          fail_count,
    output int          pending
);
    logic [15:0] max_iter;
    logic [3:0]  grad_sel;
    logic        mirror;
    logic [30:0] bg_color;
    logic [30:0] colors_due[$];

    // (c0*(n-k) + c1*k) / (n << 16), rounded half up
    function automatic logic [7:0] mix(input logic [63:0] c0, input logic [63:0] c1,
                                       input logic [63:0] k, input logic [63:0] n);
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] q;
        num = c0 * (n - k) + c1 * k;
        den = n << 16;
        q = (64'd2 * num + den) / (64'd2 * den);
        return (q > 64'd255) ? 8'd255 : q[7:0];
    endfunction

    function automatic logic [23:0] stop_level(input logic [3:0] set, input int i,
                                               input int ch);
        logic [23:0] lvl[6][3];
        lvl[0] = '{24'd0, 24'd0, 24'd0};
        case (set)
            4'd0: lvl[1] = '{FULL, 24'd0, 24'd0};
            4'd1:
            begin
                lvl[1] = '{24'd0, FULL, HALF}; lvl[2] = '{24'd0, FULL, FULL};
                lvl[3] = '{24'd0, HALF, FULL}; lvl[4] = '{24'd0, FULL, FULL};
            end
            4'd2:
            begin
                lvl[1] = '{FULL, 24'd0, 24'd0}; lvl[2] = '{FULL, FULL, 24'd0};
                lvl[3] = '{FULL, 24'd0, 24'd0};
            end
            4'd3: lvl[1] = '{24'd0, 24'd0, FULL};
            4'd4:
            begin
                lvl[1] = '{FULL, 24'd0, 24'd0}; lvl[2] = '{24'd0, 24'd0, FULL};
            end
            4'd5:
            begin
                lvl[1] = '{RED_R, RED_G, RED_B}; lvl[2] = '{VIO_R, VIO_G, VIO_B};
                lvl[3] = '{GRN_R, GRN_G, GRN_B}; lvl[4] = '{VIO_R, VIO_G, VIO_B};
            end
            4'd6:
            begin
                lvl[1] = '{RED_R, RED_G, RED_B}; lvl[2] = '{VIO_R, VIO_G, VIO_B};
                lvl[3] = '{GRN_R, GRN_G, GRN_B}; lvl[4] = '{VIO_R, VIO_G, VIO_B};
                lvl[5] = '{RED_R, RED_G, RED_B};
            end
            4'd7:
            begin
                lvl[1] = '{HALF, FULL, 24'd0}; lvl[2] = '{FULL, FULL, 24'd0};
                lvl[3] = '{FULL, HALF, 24'd0}; lvl[4] = '{FULL, FULL, 24'd0};
            end
            default: lvl[1] = '{FULL, FULL, FULL};
        endcase
        return lvl[i][ch];
    endfunction

    function automatic logic [30:0] gradient_color(input logic [15:0] cnt);
        int          pos[6];
        int          nstops;
        logic [63:0] idx;
        logic [63:0] start;
        logic [63:0] n;
        logic [7:0]  ch[3];
        bit          found;
        if (cnt >= max_iter)
            return bg_color;
        if (grad_sel >= NUM_SETS)
            return cnt[0] ? 31'hffffff : 31'd0;
        case (grad_sel)
            4'd1, 4'd5, 4'd7:
            begin
                nstops = 5; pos = '{0, 5, 10, 15, 20, 0};
            end
            4'd2:
            begin
                nstops = 4; pos = '{0, 5, 10, 20, 0, 0};
            end
            4'd4:
            begin
                nstops = 3; pos = '{0, 10, 20, 0, 0, 0};
            end
            4'd6:
            begin
                nstops = 6; pos = '{0, 4, 8, 10, 12, 20};
            end
            default:
            begin
                nstops = 2; pos = '{0, 20, 0, 0, 0, 0};
            end
        endcase
        idx = mirror ? (64'(max_iter) - 64'd1 - 64'(cnt)) : 64'(cnt);
        start = 64'd0;
        found = 0;
        for (int j = 0; j + 1 < nstops && !found; j++)
        begin
            n = (64'(pos[j+1] - pos[j]) * 64'(max_iter) * 64'd2 + 64'd20) / 64'd40;
            if (n != 0 && idx < start + n)
            begin
                for (int c = 0; c < 3; c++)
                    ch[c] = mix(64'(stop_level(grad_sel, j, c)),
                                64'(stop_level(grad_sel, j + 1, c)), idx - start, n);
                found = 1;
            end
            start += n;
        end
        // uncovered tail takes the last stop
        if (!found)
            for (int c = 0; c < 3; c++)
                ch[c] = mix(64'(stop_level(grad_sel, nstops - 1, c)),
                            64'(stop_level(grad_sel, nstops - 1, c)), 64'd0, 64'd1);
        return {7'd0, ch[0], ch[1], ch[2]};
    endfunction

    assign pending = colors_due.size();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_iter <= 16'd256;
            grad_sel <= 4'd0;
            mirror <= 1'b0;
            bg_color <= 31'd0;
            fail_count <= 0;
            colors_due.delete();
        end
        else
        begin
            if (cfg_wen)
                case (cfg_index)
                    REG_MAX_ITER:   max_iter <= cfg_data[15:0];
                    REG_COLOR_SET:  grad_sel <= cfg_data[3:0];
                    REG_DESCENDING: mirror <= cfg_data[0];
                    REG_BACKGROUND: bg_color <= cfg_data;
                    default: ;
                endcase
            if (count_fire)
                colors_due.push_back(gradient_color(count_in));
            if (color_fire)
            begin
                if (colors_due.size() == 0)
                begin
                    $error("pixel_color: unexpected item 0x%h", color_out);
                    fail_count <= fail_count + 1;
                end
                else if (colors_due[0] !== color_out)
                begin
                    $error("pixel_color: expected 0x%h, actual 0x%h", colors_due[0],
                           color_out);
                    fail_count <= fail_count + 1;
                    void'(colors_due.pop_front());
                end
                else
                    void'(colors_due.pop_front());
            end
        end
    end
endmodule

[test/tb.sv]
// Testbench top: stimulus and verdict for the iteration count color map.
module tb;
    import icgc_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        cfg_wen;
    logic [1:0]  cfg_index;
    logic [30:0] cfg_data;
    int          fail_count;
    int          pending;
    int          idle_cycles;
    bit          stall_on;

    icgc_count_if #(.WIDTH(16)) counts ();
    icgc_color_if colors ();

    iteration_count_gradient_color #(.COUNT_WIDTH(16)) dut (
        .clk(clk), .rst_n(rst_n), .counts(counts), .colors(colors),
        .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    icgc_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .count_fire(counts.valid && counts.ready), .count_in(counts.iteration_count),
        .color_fire(colors.valid && colors.ready), .color_out(colors.pixel_color),
        .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // receiver: stall in runs, with stall-free phases
    always @(posedge clk)
    begin
        if ($urandom_range(0, 15) == 0)
            stall_on <= ~stall_on;
        colors.ready <= stall_on ? ($urandom_range(0, 3) == 0) : 1'b1;
    end

    // watchdog: counts cycles with no item moving on either side
    always @(posedge clk)
    begin
        if ((counts.valid && counts.ready) || (colors.valid && colors.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000)
        begin
            $display("iteration_count_gradient_color test failed");
            $finish;
        end
    end

    // one write, then the enable returns low before the task ends
    task automatic write_reg(input logic [1:0] idx, input logic [30:0] val);
        cfg_wen <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_wen <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // send one count; hold valid until accepted
    task automatic send_count(input logic [15:0] cnt);
        counts.valid <= 1'b1;
        counts.iteration_count <= cnt;
        @(posedge clk);
        while (!counts.ready)
            @(posedge clk);
    endtask

    task automatic gap();
        counts.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
    endtask

    task automatic random_burst(input int num, input logic [15:0] limit);
        int left;
        logic [15:0] cnt;
        left = num;
        while (left > 0)
        begin
            for (int b = $urandom_range(1, 12); b > 0 && left > 0; b--)
            begin
                case ($urandom_range(0, 9))
                    0: cnt = 16'($urandom);
                    1: cnt = 16'(limit + $urandom_range(0, 2));
                    2: cnt = limit - 16'd1;
                    default: cnt = (limit == 0) ? 16'd0 : 16'($urandom_range(0, limit - 1));
                endcase
                send_count(cnt);
                left--;
            end
            if ($urandom_range(0, 2) != 0)
                gap();
        end
        counts.valid <= 1'b0;
    endtask

    logic [15:0] lim;

    initial
    begin
        rst_n = 0;
        cfg_wen = 0;
        cfg_index = REG_MAX_ITER;
        cfg_data = '0;
        counts.valid = 0;
        counts.iteration_count = '0;
        colors.ready = 0;
        stall_on = 0;
        idle_cycles = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset settings, edges of the count range
        foreach (lim[i])
            send_count(16'd1 << i);
        send_count(16'd0);
        send_count(16'd255);
        send_count(16'd256);
        send_count(16'hffff);
        counts.valid <= 1'b0;
        drain();

        // directed: sets 0, 3 and 6 and fallback sets 9, 12 and 15, descending, limits 1 and 0
        write_reg(REG_BACKGROUND, 31'h7fffffff);
        write_reg(REG_MAX_ITER, 31'd1);
        write_reg(REG_DESCENDING, 31'd1);
        for (int s = 0; s < 16; s += 3)
        begin
            write_reg(REG_COLOR_SET, 31'(s));
            send_count(16'd0);
            send_count(16'd1);
            counts.valid <= 1'b0;
            drain();
        end
        write_reg(REG_MAX_ITER, 31'd0);
        send_count(16'd0);
        counts.valid <= 1'b0;
        drain();

        // random phases across settings, extremes among them
        for (int ph = 0; ph < 22; ph++)
        begin
            case (ph % 4)
                0: lim = 16'($urandom_range(1, 40));
                1: lim = 16'($urandom_range(41, 2000));
                2: lim = 16'hffff;
                default: lim = 16'($urandom);
            endcase
            write_reg(REG_MAX_ITER, 31'(lim));
            write_reg(REG_COLOR_SET, 31'((ph < 18) ? ph % 9 : $urandom_range(9, 15)));
            write_reg(REG_DESCENDING, 31'(ph[0] ^ ph[3]));
            write_reg(REG_BACKGROUND, 31'($urandom));
            random_burst(24, lim);
            drain();
        end

        while (pending != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
        if (fail_count == 0)
            $display("iteration_count_gradient_color test passed");
        else
            $display("iteration_count_gradient_color test failed");
        $finish;
    end
endmodule
